>>> hdl/vde_pkg.sv
// package: types and constants for the vector distance engine
`default_nettype none
package vde_pkg;
    localparam int ELEM_WIDTH = 16;
    localparam int MAX_LEN    = 1024;
    localparam int ACC_W      = 48;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int PROD_W     = 2 * ELEM_WIDTH + 2;

    localparam logic [1:0] METRIC_EUCLID  = 2'd0;
    localparam logic [1:0] METRIC_SQUARED = 2'd1;
    localparam logic [1:0] METRIC_COSINE  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERONORM = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        ST_ACC, ST_FIN, ST_MUL, ST_SQRT1, ST_DIV, ST_COS, ST_OUT
    } t_state;

    typedef struct packed {
        logic       acc_en;
        logic       clear;
        logic       load;
        logic       sqrt_step;
        logic       sqrt_start;
        logic       div_start;
        logic       div_step;
        logic       cos_fin;
        logic       out_load;
        logic       sqrt_is_prod;
    } t_cmd;

    typedef struct packed {
        logic overflow;
        logic zero_norm;
        logic step_done;
    } t_stat;
endpackage
`default_nettype wire

>>> hdl/vde_ctrl.sv
// controller: sequences accumulate, root, divide and output
`default_nettype none
module vde_ctrl import vde_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_last,
    output logic            o_in_stall,
    output logic            o_valid,
    input  wire logic       i_out_stall,
    input  wire logic [1:0] i_metric,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);
    t_state r_state, n_state;
    logic   w_acc;

    assign w_acc = (r_state == ST_ACC) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (w_acc && i_last) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_stat.overflow) n_state = ST_OUT;
                else if (i_metric == METRIC_SQUARED) n_state = ST_OUT;
                else if (i_metric == METRIC_EUCLID) n_state = ST_SQRT1;
                else if (i_stat.zero_norm) n_state = ST_OUT;
                else n_state = ST_MUL;
            end
            ST_MUL:   n_state = ST_SQRT1;
            ST_SQRT1: begin
                if (i_stat.step_done) n_state = (i_metric[1]) ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (i_stat.step_done) n_state = ST_COS;
            end
            ST_COS:   n_state = ST_OUT;
            ST_OUT: begin
                if (!i_out_stall) n_state = ST_ACC;
            end
            default:  n_state = ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_in_stall   = (r_state != ST_ACC);
        o_valid      = (r_state == ST_OUT);
        o_cmd.acc_en = w_acc;
        case (r_state)
            ST_FIN: begin
                o_cmd.out_load   = 1'b1;
                o_cmd.sqrt_start = 1'b1;
            end
            ST_MUL: begin
                o_cmd.sqrt_start   = 1'b1;
                o_cmd.sqrt_is_prod = 1'b1;
            end
            ST_SQRT1: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.step_done && i_metric[1]) o_cmd.div_start = 1'b1;
                if (i_stat.step_done && !i_metric[1]) o_cmd.load = 1'b1;
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_COS:  o_cmd.cos_fin = 1'b1;
            ST_OUT:  o_cmd.clear = !i_out_stall;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/vde_dp.sv
// datapath: accumulators, product, square root and divider
`default_nettype none
module vde_dp import vde_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic signed [ELEM_WIDTH-1:0] i_elem_a,
    input  wire logic signed [ELEM_WIDTH-1:0] i_elem_b,
    input  wire logic [1:0]                   i_metric,
    input  wire t_cmd                         i_cmd,
    output t_stat                             o_stat,
    output logic [ACC_W-1:0]                  o_distance,
    output logic [1:0]                        o_status
);
    localparam int SQ_BITS = ACC_W;          // root of 96-bit value fits 48
    localparam int RAD_W   = 2 * ACC_W;
    localparam int SB_W    = $clog2(SQ_BITS);

    logic [ACC_W-1:0]        r_first, r_second, n_first, n_second;
    logic signed [ACC_W-1:0] r_cross, n_cross;
    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf, n_ovf;

    logic signed [ELEM_WIDTH:0] w_diff;
    logic [ELEM_WIDTH:0]        w_ma, w_mb, w_md;
    logic [PROD_W-1:0]          w_sqa, w_sqb, w_sqd;
    logic signed [PROD_W-1:0]   w_ab;
    logic [ACC_W:0]             w_s1, w_s2;
    logic signed [ACC_W:0]      w_sc;

    assign w_diff = $signed({i_elem_a[ELEM_WIDTH-1], i_elem_a})
                  - $signed({i_elem_b[ELEM_WIDTH-1], i_elem_b});
    assign w_ma = i_elem_a[ELEM_WIDTH-1] ? (ELEM_WIDTH+1)'(-{i_elem_a[ELEM_WIDTH-1], i_elem_a})
                                         : {1'b0, i_elem_a};
    assign w_mb = i_elem_b[ELEM_WIDTH-1] ? (ELEM_WIDTH+1)'(-{i_elem_b[ELEM_WIDTH-1], i_elem_b})
                                         : {1'b0, i_elem_b};
    assign w_md = w_diff[ELEM_WIDTH] ? (ELEM_WIDTH+1)'(-w_diff) : w_diff;
    assign w_sqa = PROD_W'(w_ma * w_ma);
    assign w_sqb = PROD_W'(w_mb * w_mb);
    assign w_sqd = PROD_W'(w_md * w_md);
    assign w_ab  = PROD_W'(i_elem_a * i_elem_b);

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_cross  = r_cross;
        n_ovf    = r_ovf || (r_count == CNT_W'(MAX_LEN));
        if (i_metric[1]) begin
            w_s1 = {1'b0, r_first} + (ACC_W+1)'(w_sqa);
        end else begin
            w_s1 = {1'b0, r_first} + (ACC_W+1)'(w_sqd);
        end
        w_s2 = {1'b0, r_second} + (ACC_W+1)'(w_sqb);
        w_sc = (ACC_W+1)'(r_cross) + (ACC_W+1)'(w_ab);
        if (w_s1[ACC_W]) begin
            n_ovf   = 1'b1;
            n_first = '1;
        end else begin
            n_first = w_s1[ACC_W-1:0];
        end
        if (i_metric[1]) begin
            if (w_s2[ACC_W]) begin
                n_ovf    = 1'b1;
                n_second = '1;
            end else begin
                n_second = w_s2[ACC_W-1:0];
            end
            if (w_sc[ACC_W] != w_sc[ACC_W-1]) n_ovf = 1'b1;
            else n_cross = w_sc[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_first  <= '0;
            r_second <= '0;
            r_cross  <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.acc_en) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_cross  <= n_cross;
            r_ovf    <= n_ovf;
            if (r_count != CNT_W'(MAX_LEN)) r_count <= r_count + CNT_W'(1);
        end
    end

    // 48x48 product from four registered 24x24 partial products
    localparam int HW = ACC_W / 2;
    logic [RAD_W-1:0] r_prod;
    logic [2*HW-1:0]  w_p00, w_p01, w_p10, w_p11;
    assign w_p00 = r_first[HW-1:0] * r_second[HW-1:0];
    assign w_p01 = r_first[HW-1:0] * r_second[ACC_W-1:HW];
    assign w_p10 = r_first[ACC_W-1:HW] * r_second[HW-1:0];
    assign w_p11 = r_first[ACC_W-1:HW] * r_second[ACC_W-1:HW];
    logic [2*HW-1:0] r_p00, r_p01, r_p10, r_p11;
    always_ff @(posedge i_clk) begin
        r_p00 <= w_p00;
        r_p01 <= w_p01;
        r_p10 <= w_p10;
        r_p11 <= w_p11;
    end
    assign r_prod = {r_p11, r_p00}
                  + (RAD_W'(r_p01) << HW) + (RAD_W'(r_p10) << HW);

    // restoring square root, one result bit per cycle
    logic [RAD_W-1:0]   r_rad;
    logic [SQ_BITS-1:0] r_root;
    logic [RAD_W+1:0]   r_rem;
    logic [SB_W-1:0]    r_sbit;
    logic [RAD_W+1:0]   w_rem_sh, w_trial;
    assign w_rem_sh = {r_rem[RAD_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = (RAD_W+2)'({r_root, 2'b01});

    // restoring divider, one quotient bit per cycle
    localparam int Q_W = ACC_W + 16;
    logic [Q_W-1:0]   r_quo;
    logic [ACC_W:0]   r_drem;
    logic [ACC_W-1:0] r_div;
    logic [Q_W-1:0]   r_num;
    logic [6:0]       r_dcnt;
    logic [ACC_W:0]   w_dsh;
    logic [ACC_W-1:0] w_abs;
    assign w_abs = r_cross[ACC_W-1] ? ACC_W'(-r_cross) : r_cross;
    assign w_dsh = {r_drem[ACC_W-1:0], r_num[Q_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rad  <= i_cmd.sqrt_is_prod ? r_prod : RAD_W'(r_first);
            r_root <= '0;
            r_rem  <= '0;
            r_sbit <= SB_W'(SQ_BITS - 1);
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= r_rad << 2;
            r_sbit <= r_sbit - SB_W'(1);
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[SQ_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[SQ_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.div_start) begin
            r_div  <= {r_root[SQ_BITS-2:0], (w_rem_sh >= w_trial)};
            r_num  <= {w_abs, 16'd0};
            r_drem <= '0;
            r_quo  <= '0;
            r_dcnt <= 7'(Q_W - 1);
        end else if (i_cmd.div_step) begin
            r_num  <= r_num << 1;
            r_dcnt <= r_dcnt - 7'd1;
            if (w_dsh >= {1'b0, r_div}) begin
                r_drem <= w_dsh - {1'b0, r_div};
                r_quo  <= {r_quo[Q_W-2:0], 1'b1};
            end else begin
                r_drem <= w_dsh;
                r_quo  <= {r_quo[Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.overflow  = r_ovf;
    assign o_stat.zero_norm = (r_first == '0) || (r_second == '0);
    assign o_stat.step_done = i_cmd.sqrt_step ? (r_sbit == '0) : (r_dcnt == '0);

    logic [16:0] w_q;
    assign w_q = (r_quo > Q_W'(65536)) ? 17'd65536 : r_quo[16:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_distance <= r_first;
            o_status   <= STATUS_OK;
            if (r_ovf) begin
                o_status   <= STATUS_OVERFLOW;
                o_distance <= '0;
            end else if (i_metric[1] && ((r_first == '0) || (r_second == '0))) begin
                o_status   <= STATUS_ZERONORM;
                o_distance <= '0;
            end
        end else if (i_cmd.load) begin
            o_distance <= {r_root[SQ_BITS-2:0], (w_rem_sh >= w_trial)};
        end else if (i_cmd.cos_fin) begin
            o_distance <= r_cross[ACC_W-1] ? ACC_W'(18'd65536 + 18'(w_q))
                                           : ACC_W'(18'd65536 - 18'(w_q));
        end
    end
endmodule
`default_nettype wire

>>> hdl/vector_distance_engine.sv
// Vector distance engine: takes one element pair per cycle while accumulating;
// after the last pair a tail runs before the next vector is accepted: squared
// metric just loads the result, Euclidean takes a root (one root bit per cycle),
// cosine a product, a root of the 96-bit norm product and a divide; each tail
// also holds while the result word waits on a stall.
`default_nettype none
module vector_distance_engine import vde_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [ELEM_WIDTH-1:0] i_elem_a,
    input  wire logic signed [ELEM_WIDTH-1:0] i_elem_b,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [ACC_W-1:0]                  o_distance,
    output logic [1:0]                        o_status,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_data
);
    logic [1:0] r_metric;
    t_cmd       w_cmd;
    t_stat      w_stat;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_EUCLID;
        end else if (i_cfg_valid) begin
            r_metric <= i_cfg_data;
        end
    end

    vde_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_last,
        .o_in_stall(o_stall), .o_valid, .i_out_stall(i_stall),
        .i_metric(r_metric), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    vde_dp u_dp (
        .i_clk, .i_rst_n, .i_elem_a, .i_elem_b,
        .i_metric(r_metric), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_distance, .o_status
    );
endmodule
`default_nettype wire
